FILE: design/dsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimiter sequence finder package
// Shared payload types, configuration layout and search mode codes.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int DELIM_REG_BITS = 64;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;
  localparam int LEN_BITS       = 4;
  localparam int OCC_BITS       = 8;
  localparam int MODE_BITS      = 2;
  localparam int OUT_POS_BITS   = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OCCURRENCE   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEARCH_MODE  = 2'd3;

  // Search modes.
  localparam logic [MODE_BITS-1:0] MODE_NTH_START  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FIRST_END  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LAST_END   = 2'd2;

  localparam logic [OCC_BITS-1:0] MATCH_COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                    found;
    logic [OUT_POS_BITS-1:0] position;
    logic                    too_long;
  } out_t;

  typedef struct packed {
    logic [DELIM_REG_BITS-1:0] delimiter_bytes;
    logic [LEN_BITS-1:0]       delimiter_length;
    logic [OCC_BITS-1:0]       occurrence;
    logic [MODE_BITS-1:0]      search_mode;
  } cfg_t;

endpackage

FILE: design/dsf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimiter sequence finder window cell
// Holds one byte of the recent window, passes it on, and compares the byte
// it is about to take with its delimiter byte.
// ----------------------------------------------------------------------------
module dsf_cell #(
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift,
  input  logic                                clear,
  input  logic [7:0]                          byte_in,
  input  logic                                valid_in,
  input  logic [dsf_pkg::DELIM_REG_BITS-1:0]  delimiter_bytes,
  input  logic [dsf_pkg::LEN_BITS-1:0]        delimiter_length,
  output logic [7:0]                          byte_out,
  output logic                                valid_out,
  output logic                                ok
);

  localparam logic [4:0] POS = 5'(INDEX);

  logic [7:0] win_byte;
  logic       win_valid;
  logic       cmp_on;
  logic [4:0] sel;
  logic [7:0] delim_sel;

  // The cell at window index k checks delimiter byte (length - 1 - k).
  always_comb begin
    cmp_on    = POS < {1'b0, delimiter_length};
    sel       = {1'b0, delimiter_length} - POS - 5'd1;
    delim_sel = (sel < 5'd8) ? delimiter_bytes[{sel[2:0], 3'b000} +: 8] : 8'h00;
    ok        = !cmp_on || (valid_in && (byte_in == delim_sel));
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      win_byte <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (shift) begin
      win_valid <= clear ? 1'b0 : valid_in;
    end
  end

  assign byte_out  = win_byte;
  assign valid_out = win_valid;

endmodule

FILE: design/dsf_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimiter sequence finder match tracker
// Counts bytes and matches of one buffer and keeps the requested hit.
// ----------------------------------------------------------------------------
module dsf_tracker #(
  parameter int POS_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 last,
  input  logic                 window_match,
  input  dsf_pkg::cfg_t        cfg,
  output dsf_pkg::out_t        result
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  logic [POS_BITS-1:0]          byte_count, byte_count_next;
  logic [dsf_pkg::OCC_BITS-1:0] match_count, match_count_next;
  logic                         hit_flag, hit_flag_next;
  logic [POS_BITS-1:0]          hit_position, hit_position_next;
  logic                         overflow_flag, overflow_flag_next;
  logic [POS_BITS-1:0]          start_pos;
  logic [POS_BITS+dsf_pkg::OUT_POS_BITS-1:0] pos_wide;

  always_comb begin
    overflow_flag_next = overflow_flag || (byte_count == POS_MAX);
    byte_count_next    = (byte_count == POS_MAX) ? byte_count : byte_count + 1'b1;
    start_pos          = byte_count_next - POS_BITS'(cfg.delimiter_length);
    match_count_next   = match_count;
    hit_flag_next      = hit_flag;
    hit_position_next  = hit_position;
    if (window_match) begin
      if (match_count != dsf_pkg::MATCH_COUNT_MAX) begin
        match_count_next = match_count + 1'b1;
      end
      case (cfg.search_mode)
        dsf_pkg::MODE_NTH_START: begin
          if (!hit_flag && (cfg.occurrence != '0) && (match_count_next == cfg.occurrence)) begin
            hit_flag_next     = 1'b1;
            hit_position_next = start_pos;
          end
        end
        dsf_pkg::MODE_FIRST_END: begin
          if (!hit_flag) begin
            hit_flag_next     = 1'b1;
            hit_position_next = byte_count_next;
          end
        end
        dsf_pkg::MODE_LAST_END: begin
          hit_flag_next     = 1'b1;
          hit_position_next = byte_count_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Result for a buffer ending on this byte.
  always_comb begin
    pos_wide        = {{dsf_pkg::OUT_POS_BITS{1'b0}}, hit_position_next};
    result.found    = hit_flag_next;
    result.position = hit_flag_next ? pos_wide[dsf_pkg::OUT_POS_BITS-1:0] : '0;
    result.too_long = overflow_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      match_count   <= '0;
      hit_flag      <= 1'b0;
      hit_position  <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      if (last) begin
        byte_count    <= '0;
        match_count   <= '0;
        hit_flag      <= 1'b0;
        hit_position  <= '0;
        overflow_flag <= 1'b0;
      end else begin
        byte_count    <= byte_count_next;
        match_count   <= match_count_next;
        hit_flag      <= hit_flag_next;
        hit_position  <= hit_position_next;
        overflow_flag <= overflow_flag_next;
      end
    end
  end

endmodule

FILE: design/delimiter_sequence_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimiter sequence finder
// Searches a byte stream for a configured delimiter with a chain of cells.
// ----------------------------------------------------------------------------
// Usage: a buffer enters one byte per request on the in channel, with
// last_byte set on its final byte. Every accepted byte shifts the window
// chain by one cell; each cell compares the byte it takes with its delimiter
// byte, so a match is seen in the same cycle the byte is accepted.
// Only the last byte of a buffer produces a request on the out channel:
// found, the position of the requested match and the too_long flag.
// The result is registered; it is valid in the cycle after its last byte is
// accepted. Throughput: one byte per cycle while in_ready is high; buffers
// follow each other with no gap while out_ready is high.
// The result sits in an output register. While it waits, the input takes
// no bytes at all, whether they are last bytes or not; in_ready is low
// exactly when the output register is full and not being taken.
// Reset clears the configuration to its defaults (length 1, occurrence 1,
// nth-start mode, delimiter zero), all per-buffer counters, the window valid
// bits and the output valid flag. Configuration is written through cfg_write,
// cfg_index and cfg_data and takes effect from the next byte.
// ----------------------------------------------------------------------------
module delimiter_sequence_finder #(
  parameter int DELIM_MAX = 8,
  parameter int POS_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dsf_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dsf_pkg::out_t                       out_data,
  input  logic                                cfg_write,
  input  logic [dsf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [dsf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  dsf_pkg::cfg_t cfg;
  dsf_pkg::out_t result;

  logic             accept;
  logic             clear;
  logic             len_ok;
  logic             window_match;
  logic [7:0]       byte_chain  [0:DELIM_MAX];
  logic             valid_chain [0:DELIM_MAX];
  logic [DELIM_MAX-1:0] cell_ok;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign clear    = in_data.last_byte;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_bytes  <= '0;
      cfg.delimiter_length <= dsf_pkg::LEN_BITS'(1);
      cfg.occurrence       <= dsf_pkg::OCC_BITS'(1);
      cfg.search_mode      <= dsf_pkg::MODE_NTH_START;
    end else if (cfg_write) begin
      case (cfg_index)
        dsf_pkg::REG_DELIM_BYTES:  cfg.delimiter_bytes  <= cfg_data;
        dsf_pkg::REG_DELIM_LENGTH: cfg.delimiter_length <= cfg_data[dsf_pkg::LEN_BITS-1:0];
        dsf_pkg::REG_OCCURRENCE:   cfg.occurrence       <= cfg_data[dsf_pkg::OCC_BITS-1:0];
        dsf_pkg::REG_SEARCH_MODE:  cfg.search_mode      <= cfg_data[dsf_pkg::MODE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Window chain: cell 0 takes the incoming byte, cell k the byte of cell k-1.
  assign byte_chain[0]  = in_data.data_byte;
  assign valid_chain[0] = 1'b1;

  for (genvar k = 0; k < DELIM_MAX; k++) begin : g_cell
    dsf_cell #(
      .INDEX (k)
    ) u_cell (
      .clk              (clk),
      .rst              (rst),
      .shift            (accept),
      .clear            (clear),
      .byte_in          (byte_chain[k]),
      .valid_in         (valid_chain[k]),
      .delimiter_bytes  (cfg.delimiter_bytes),
      .delimiter_length (cfg.delimiter_length),
      .byte_out         (byte_chain[k+1]),
      .valid_out        (valid_chain[k+1]),
      .ok               (cell_ok[k])
    );
  end

  // A zero length or one longer than the chain never matches.
  assign len_ok       = (cfg.delimiter_length != '0) &&
                        ({1'b0, cfg.delimiter_length} <= 5'(DELIM_MAX));
  assign window_match = accept && len_ok && (&cell_ok);

  dsf_tracker #(
    .POS_BITS (POS_BITS)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .last         (in_data.last_byte),
    .window_match (window_match),
    .cfg          (cfg),
    .result       (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_data <= result;
    end
  end

endmodule

FILE: design/dsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimiter sequence finder port checker
// Watches the top-level ports for result timing and consistency.
// ----------------------------------------------------------------------------
module dsf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input dsf_pkg::in_t                        in_data,
  input logic                                out_valid,
  input logic                                out_ready,
  input dsf_pkg::out_t                       out_data,
  input logic                                cfg_write,
  input logic [dsf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input logic [dsf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A last byte gives its result on the next cycle.
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_byte |=> out_valid)
    else $error("no result after last byte");

  // Bytes that are not last never create a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready && in_data.last_byte) |=> !out_valid)
    else $error("result without a last byte");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("position set without a match");

endmodule

bind delimiter_sequence_finder dsf_checker u_dsf_checker (.*);
